// File: hw/rtl/shelf_atlas_allocator_defines.svh
// ----------------------------------------------------------------------------
// Shelf atlas allocator assertion macros
// Immediate-implication and next-cycle checks, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SHELF_ATLAS_ALLOCATOR_DEFINES_SVH
`define SHELF_ATLAS_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define SAP_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define SAP_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define SAP_ASSERT_IMPLY(label, clk, rst, a, c)
`define SAP_ASSERT_NEXT(label, clk, rst, a, c)
`endif

`endif

// File: hw/rtl/sap_pkg.sv
// ----------------------------------------------------------------------------
// Shelf atlas allocator package
// Row entry layout, evaluation flags, state, register and operation codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sap_pkg;

  typedef struct packed {
    logic [13:0] height;
    logic [12:0] top;
    logic [13:0] fill;
  } row_entry_t;

  typedef struct packed {
    logic ge_h;      // row at least as tall as request
    logic gt_h;      // row strictly taller than request
    logic too_tall;  // row beyond tolerance
    logic fits;      // free width suffices
  } row_eval_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_SDRAIN,
    ST_NEWROW
  } state_t;

  localparam logic [1:0] CFG_PAGE_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_PAGE_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_TOLERANCE   = 2'd2;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

endpackage

// File: hw/rtl/shelf_atlas_allocator.sv
// ----------------------------------------------------------------------------
// Shelf atlas allocator
// Places rectangles on height-sorted shelves of a texture page.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown for one cycle with done high; the receiver must
// take it then, there is no back-pressure. A clear or an over-wide request
// answers in the cycle after acceptance. A place request scans the row table
// held in a single-port-read memory, one row per cycle; opening a new row
// adds a write of the new entry, and opening it in the middle of the table
// first moves the rows from the insertion point on one entry further along,
// one entry at a time. Configuration words are accepted at any time
// (cfg_ready is always high) but should only be written while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "shelf_atlas_allocator_defines.svh"

module shelf_atlas_allocator #(
  parameter int MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [13:0] req_width,
  input  logic [13:0] req_height,
  // result channel
  output logic        done,
  output logic        placed,
  output logic [12:0] pos_x,
  output logic [12:0] pos_y,
  output logic [15:0] slot_index,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [13:0] cfg_data
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);

  // configuration registers
  logic [13:0] page_width;
  logic [13:0] page_height;
  logic [7:0]  tolerance_tenths;

  // page state
  logic [CW-1:0] row_count;
  logic [13:0]   next_free_y;
  logic [15:0]   placement_count;

  // request being worked on
  sap_pkg::state_t state, state_next;
  logic [13:0]   rw;
  logic [13:0]   rh;
  logic [21:0]   limit;

  // scan bookkeeping
  logic [CW-1:0] iss;
  logic          pend;
  logic [AW-1:0] pend_idx;
  logic          broken;
  logic          p0_hit;
  logic [AW-1:0] p0_idx;
  logic [13:0]   p0_height;
  logic [13:0]   p0_fill;
  logic [12:0]   p0_top;
  logic          p1_hit;
  logic [AW-1:0] p1_idx;
  logic [13:0]   p1_height;
  logic [13:0]   p1_fill;
  logic [12:0]   p1_top;
  logic          ins_hit;
  logic [AW-1:0] ins_idx;

  // shift bookkeeping
  logic [AW-1:0] sh;
  logic          shw;
  logic [AW-1:0] shw_idx;

  // memory ports
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  sap_pkg::row_entry_t rd_data;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  sap_pkg::row_entry_t wr_data;
  sap_pkg::row_eval_t  ev;

  // result to register
  logic        emit;
  logic        emit_placed;
  logic [12:0] emit_x;
  logic [12:0] emit_y;

  logic          accept;
  logic          room;
  logic          full;
  logic [AW-1:0] ins_sel;
  logic [14:0]   bottom;

  assign accept    = start && !busy;
  assign busy      = state != sap_pkg::ST_IDLE;
  assign cfg_ready = 1'b1;
  assign bottom    = {1'b0, next_free_y} + {1'b0, rh};
  assign room      = bottom <= {1'b0, page_height};
  assign full      = row_count == CW'(MAX_ROWS);
  // no taller row seen: the new row goes at the end of the table
  assign ins_sel   = ins_hit ? ins_idx : row_count[AW-1:0];

  sap_row_ram #(
    .DEPTH (MAX_ROWS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  sap_row_eval u_eval (
    .entry      (rd_data),
    .req_w      (rw),
    .req_h      (rh),
    .limit      (limit),
    .page_width (page_width),
    .flags      (ev)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      page_width       <= 14'd2048;
      page_height      <= 14'd2048;
      tolerance_tenths <= 8'd12;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sap_pkg::CFG_PAGE_WIDTH:  page_width       <= cfg_data;
        sap_pkg::CFG_PAGE_HEIGHT: page_height      <= cfg_data;
        sap_pkg::CFG_TOLERANCE:   tolerance_tenths <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      sap_pkg::ST_IDLE: begin
        if (accept && operation == sap_pkg::OP_PLACE && req_width <= page_width) begin
          state_next = sap_pkg::ST_SCAN;
        end
      end
      sap_pkg::ST_SCAN: begin
        if (iss == row_count && !pend) begin
          state_next = sap_pkg::ST_DECIDE;
        end
      end
      sap_pkg::ST_DECIDE: begin
        priority if (p0_hit) begin
          state_next = sap_pkg::ST_IDLE;
        end else if (room) begin
          priority if (full)    state_next = sap_pkg::ST_IDLE;
          else if (ins_hit)     state_next = sap_pkg::ST_SHIFT;
          else                  state_next = sap_pkg::ST_NEWROW;
        end else begin
          state_next = sap_pkg::ST_IDLE;
        end
      end
      sap_pkg::ST_SHIFT: begin
        if (sh == ins_idx) begin
          state_next = sap_pkg::ST_SDRAIN;
        end
      end
      sap_pkg::ST_SDRAIN: state_next = sap_pkg::ST_NEWROW;
      sap_pkg::ST_NEWROW: state_next = sap_pkg::ST_IDLE;
      default:            state_next = sap_pkg::ST_IDLE;
    endcase
  end

  // memory control and result
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = rd_data;
    emit        = 1'b0;
    emit_placed = 1'b0;
    emit_x      = '0;
    emit_y      = '0;
    unique case (state)
      sap_pkg::ST_IDLE: begin
        // clear and over-wide requests answer at once
        if (accept && (operation == sap_pkg::OP_CLEAR || req_width > page_width)) begin
          emit = 1'b1;
        end
      end
      sap_pkg::ST_SCAN: begin
        if (iss < row_count) begin
          rd_en   = 1'b1;
          rd_addr = iss[AW-1:0];
        end
      end
      sap_pkg::ST_DECIDE: begin
        priority if (p0_hit) begin
          wr_en        = 1'b1;
          wr_addr      = p0_idx;
          wr_data      = '{height: p0_height, top: p0_top, fill: p0_fill + rw};
          emit         = 1'b1;
          emit_placed  = 1'b1;
          emit_x       = p0_fill[12:0];
          emit_y       = p0_top;
        end else if (room) begin
          emit = full;
        end else if (p1_hit) begin
          // retry without tolerance
          wr_en        = 1'b1;
          wr_addr      = p1_idx;
          wr_data      = '{height: p1_height, top: p1_top, fill: p1_fill + rw};
          emit         = 1'b1;
          emit_placed  = 1'b1;
          emit_x       = p1_fill[12:0];
          emit_y       = p1_top;
        end else begin
          emit = 1'b1;
        end
      end
      sap_pkg::ST_SHIFT: begin
        rd_en   = 1'b1;
        rd_addr = sh;
        if (shw) begin
          wr_en   = 1'b1;
          wr_addr = shw_idx + AW'(1);
          wr_data = rd_data;
        end
      end
      sap_pkg::ST_SDRAIN: begin
        wr_en   = 1'b1;
        wr_addr = shw_idx + AW'(1);
        wr_data = rd_data;
      end
      sap_pkg::ST_NEWROW: begin
        wr_en       = 1'b1;
        wr_addr     = ins_sel;
        wr_data     = '{height: rh, top: next_free_y[12:0], fill: rw};
        emit        = 1'b1;
        emit_placed = 1'b1;
        emit_x      = '0;
        emit_y      = next_free_y[12:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sap_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // page state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count       <= '0;
      next_free_y     <= '0;
      placement_count <= '0;
      done            <= 1'b0;
    end else begin
      done <= emit;
      if (state == sap_pkg::ST_IDLE && accept && operation == sap_pkg::OP_CLEAR) begin
        row_count       <= '0;
        next_free_y     <= '0;
        placement_count <= '0;
      end else begin
        if (emit && emit_placed) begin
          placement_count <= placement_count + 16'd1;
        end
        if (state == sap_pkg::ST_NEWROW) begin
          row_count   <= row_count + CW'(1);
          next_free_y <= bottom[13:0];
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      placed     <= emit_placed;
      pos_x      <= emit_x;
      pos_y      <= emit_y;
      slot_index <= emit_placed ? placement_count : 16'd0;
    end
  end

  // request, scan and shift bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      shw  <= 1'b0;
    end else begin
      unique case (state)
        sap_pkg::ST_IDLE: begin
          if (accept) begin
            rw      <= req_width;
            rh      <= req_height;
            limit   <= {8'd0, req_height} * {14'd0, tolerance_tenths};
            iss     <= '0;
            pend    <= 1'b0;
            broken  <= 1'b0;
            p0_hit  <= 1'b0;
            p1_hit  <= 1'b0;
            ins_hit <= 1'b0;
            shw     <= 1'b0;
          end
        end
        sap_pkg::ST_SCAN: begin
          pend     <= rd_en;
          pend_idx <= iss[AW-1:0];
          if (rd_en) begin
            iss <= iss + CW'(1);
          end
          // rows shorter than the request are skipped; they lie at the start of the table
          if (pend && ev.ge_h) begin
            if (!broken && ev.too_tall) begin
              broken <= 1'b1;
            end else if (!broken && ev.fits && !p0_hit) begin
              p0_hit    <= 1'b1;
              p0_idx    <= pend_idx;
              p0_height <= rd_data.height;
              p0_fill   <= rd_data.fill;
              p0_top    <= rd_data.top;
            end
            if (ev.fits && !p1_hit) begin
              p1_hit    <= 1'b1;
              p1_idx    <= pend_idx;
              p1_height <= rd_data.height;
              p1_fill   <= rd_data.fill;
              p1_top    <= rd_data.top;
            end
            if (ev.gt_h && !ins_hit) begin
              ins_hit <= 1'b1;
              ins_idx <= pend_idx;
            end
          end
        end
        sap_pkg::ST_DECIDE: begin
          sh <= row_count[AW-1:0] - AW'(1);
        end
        sap_pkg::ST_SHIFT: begin
          shw     <= 1'b1;
          shw_idx <= sh;
          if (sh != ins_idx) begin
            sh <= sh - AW'(1);
          end
        end
        sap_pkg::ST_SDRAIN: ;
        sap_pkg::ST_NEWROW: shw <= 1'b0;
        default: ;
      endcase
    end
  end

  `SAP_ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, row_count <= CW'(MAX_ROWS))
  `SAP_ASSERT_NEXT(a_clear_answers, clk, rst, accept && operation == sap_pkg::OP_CLEAR, done && !placed && row_count == '0)
  `SAP_ASSERT_IMPLY(a_placed_has_row, clk, rst, done && placed, row_count != '0)
  `SAP_ASSERT_IMPLY(a_scan_bound, clk, rst, state == sap_pkg::ST_SCAN, iss <= row_count)

endmodule

// File: hw/rtl/sap_row_ram.sv
// ----------------------------------------------------------------------------
// Shelf row memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sap_row_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output sap_pkg::row_entry_t   rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  sap_pkg::row_entry_t   wr_data
);

  sap_pkg::row_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/sap_row_eval.sv
// ----------------------------------------------------------------------------
// Shelf row evaluator
// Compares one row entry against the pending request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sap_row_eval (
  input  sap_pkg::row_entry_t entry,
  input  logic [13:0]         req_w,
  input  logic [13:0]         req_h,
  input  logic [21:0]         limit,
  input  logic [13:0]         page_width,
  output sap_pkg::row_eval_t  flags
);

  logic [17:0] height_x10;
  logic [14:0] fill_sum;

  assign height_x10     = {4'd0, entry.height} * 18'd10;
  assign fill_sum       = {1'b0, entry.fill} + {1'b0, req_w};
  assign flags.ge_h     = entry.height >= req_h;
  assign flags.gt_h     = entry.height > req_h;
  assign flags.too_tall = {4'd0, height_x10} > limit;
  assign flags.fits     = fill_sum <= {1'b0, page_width};

endmodule
